FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the stencil step rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define HDS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define HDS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/hds_pkg.sv
// types and constants of the heat diffusion stencil step
package hds_pkg;

    // field widths
    localparam int CELL_W      = 32;
    localparam int ROW_F_W     = 10;
    localparam int COL_F_W     = 8;
    localparam int GRID_ROWS_W = 11;
    localparam int GRID_COLS_W = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // fixed point arithmetic widths
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * CELL_W;
    localparam int SUM_W  = PROD_W - FRAC_W + 1;
    localparam int HI_W   = SUM_W - FRAC_W;
    localparam int PH_W   = CELL_W + HI_W;
    localparam int PL_W   = CELL_W + FRAC_W + 1;
    localparam int TERM_W = PH_W + 1;
    localparam int SAT_W  = TERM_W + 1;

    // smallest grid dimension
    localparam int GRID_MIN = 3;

    // reset values of the registers
    localparam logic [GRID_ROWS_W-1:0] ROWS_RESET   = 11'd8;
    localparam logic [GRID_COLS_W-1:0] COLS_RESET   = 9'd8;
    localparam logic signed [CELL_W-1:0] WEIGHT_RESET = 32'sd16384;
    localparam logic signed [CELL_W-1:0] DIAG_RESET   = 32'sd0;

    // saturation limits
    localparam logic signed [CELL_W-1:0] CELL_MAX = 32'sh7fff_ffff;
    localparam logic signed [CELL_W-1:0] CELL_MIN = 32'sh8000_0000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS = 3'd0,
        REG_GRID_COLS = 3'd1,
        REG_WEIGHT_X  = 3'd2,
        REG_WEIGHT_Y  = 3'd3,
        REG_DIAG_X    = 3'd4,
        REG_DIAG_Y    = 3'd5
    } hds_reg_t;

    // per-cell control carried down the pipeline
    typedef struct packed {
        logic               first_v;
        logic               second_v;
        logic               border;
        logic [ROW_F_W-1:0] row;
        logic [COL_F_W-1:0] col;
        logic               last;
    } hds_tag_t;

    // stencil coefficients
    typedef struct packed {
        logic signed [CELL_W-1:0] wx;
        logic signed [CELL_W-1:0] wy;
        logic signed [CELL_W-1:0] dx;
        logic signed [CELL_W-1:0] dy;
    } hds_coef_t;

endpackage

FILE: hw/rtl/hds_in_if.sv
// input channel carrying one old cell value per word
interface hds_in_if import hds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

FILE: hw/rtl/hds_out_if.sv
// result channel carrying one updated cell per word
interface hds_out_if import hds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] new_value;
    logic [ROW_F_W-1:0]       out_row;
    logic [COL_F_W-1:0]       out_col;
    logic                     frame_last;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink (input valid, input new_value, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

FILE: hw/rtl/heat_diffusion_stencil_step_unit.sv
// top level of the heat diffusion stencil step: counters, row memories, result stage
`include "assert_macros.svh"

// One explicit heat-diffusion step over a grid streamed in raster order. The block takes
// one cell per clock for as long as results are taken; each cell of the last row gives
// two results through the one result port, and the input waits while both of a cell's results are held.
// A cell's result is offered after the memory read on the accepting edge, four arithmetic
// stages and the saturating result register. The two
// previous rows sit in two row memories that swap roles at each row end; each cell writes
// the older memory once and reads both memories at the current and the next column, so
// left, centre, right and up all come from those reads and a one-word window.
// The memories are not cleared after reset and need no clearing pass: rows zero and one of
// every frame fill them, and no word of either is used before it is written.
module heat_diffusion_stencil_step_unit import hds_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hds_in_if.sink                cells,
    hds_out_if.source             results
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // configuration registers
    logic [GRID_ROWS_W-1:0]   grid_rows_reg;
    logic [GRID_COLS_W-1:0]   grid_cols_reg;
    hds_coef_t                coef_reg;

    // position state
    logic [ROW_W-1:0]         row_cnt_reg;
    logic [COL_W-1:0]         col_cnt_reg;
    logic                     sel_reg;

    // row memories and their read registers
    logic signed [CELL_W-1:0] mem_a [MAX_COLS];
    logic signed [CELL_W-1:0] mem_b [MAX_COLS];
    logic signed [CELL_W-1:0] a_rd0_reg, a_rd1_reg, b_rd0_reg, b_rd1_reg;

    // first pipeline stage
    logic                     s1_valid_reg;
    logic                     s1_sel_reg;
    hds_tag_t                 s1_tag_reg;
    logic signed [CELL_W-1:0] s1_cell_reg;
    logic signed [CELL_W-1:0] left_reg;
    logic signed [CELL_W-1:0] s1_c, s1_up, s1_right;

    // result stage
    logic                     out_first_reg, out_second_reg;
    logic signed [CELL_W-1:0] out_val1_reg, out_val2_reg;
    hds_tag_t                 out_tag_reg;

    // arithmetic outputs
    logic                     ar_valid;
    hds_tag_t                 ar_tag;
    logic signed [CELL_W-1:0] ar_c, ar_cell;
    logic signed [TERM_W-1:0] ar_tx, ar_ty;
    logic signed [SAT_W-1:0]  sum;
    logic signed [CELL_W-1:0] sat_val;

    logic [COL_W-1:0]         cols_last, j, j_plus;
    logic [ROW_W-1:0]         rows_last, i;
    logic                     last_col, last_row;
    logic                     adv, accept;
    hds_tag_t                 tag_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROWS_RESET;
            grid_cols_reg <= COLS_RESET;
            coef_reg.wx   <= WEIGHT_RESET;
            coef_reg.wy   <= WEIGHT_RESET;
            coef_reg.dx   <= DIAG_RESET;
            coef_reg.dy   <= DIAG_RESET;
        end
        else if (cfg_write)
        begin
            case (hds_reg_t'(cfg_index))
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_ROWS_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_COLS_W-1:0];
                REG_WEIGHT_X:  coef_reg.wx   <= $signed(cfg_data);
                REG_WEIGHT_Y:  coef_reg.wy   <= $signed(cfg_data);
                REG_DIAG_X:    coef_reg.dx   <= $signed(cfg_data);
                REG_DIAG_Y:    coef_reg.dy   <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // clamped last column and last row
    always_comb
    begin
        if (grid_cols_reg < GRID_COLS_W'(GRID_MIN))
            cols_last = COL_W'(GRID_MIN - 1);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            cols_last = COL_W'(MAX_COLS - 1);
        else
            cols_last = COL_W'(grid_cols_reg - GRID_COLS_W'(1));

        if (grid_rows_reg < GRID_ROWS_W'(GRID_MIN))
            rows_last = ROW_W'(GRID_MIN - 1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            rows_last = ROW_W'(MAX_ROWS - 1);
        else
            rows_last = ROW_W'(grid_rows_reg - GRID_ROWS_W'(1));
    end

    // position of the incoming cell
    assign last_col = (col_cnt_reg >= cols_last);
    assign last_row = (row_cnt_reg >= rows_last);
    assign j        = (col_cnt_reg > cols_last) ? cols_last : col_cnt_reg;
    assign j_plus   = j + COL_W'(1);
    assign i        = last_row ? rows_last : row_cnt_reg;

    // control tag of the incoming cell
    always_comb
    begin
        tag_next.first_v  = (i != '0);
        tag_next.second_v = last_row;
        tag_next.border   = (i == ROW_W'(1)) || (j == '0) || last_col;
        tag_next.row      = ROW_F_W'(i);
        tag_next.col      = COL_F_W'(j);
        tag_next.last     = last_col;
    end

    // handshake: the pipeline moves when the result stage will be free
    assign adv         = !(out_first_reg || out_second_reg)
                       || (results.ready && !(out_first_reg && out_second_reg));
    assign accept      = cells.valid && adv;
    assign cells.ready = adv;

    // position counters and memory role
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            sel_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_cnt_reg <= '0;
                sel_reg     <= !sel_reg;
                row_cnt_reg <= last_row ? '0 : (i + ROW_W'(1));
            end
            else
            begin
                col_cnt_reg <= j_plus;
                row_cnt_reg <= i;
            end
        end
    end

    // row memory a: older row while sel is high
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_rd0_reg <= mem_a[j];
            a_rd1_reg <= mem_a[j_plus];
            if (sel_reg)
                mem_a[j] <= cells.cell_value;
        end
    end

    // row memory b: older row while sel is low
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_rd0_reg <= mem_b[j];
            b_rd1_reg <= mem_b[j_plus];
            if (!sel_reg)
                mem_b[j] <= cells.cell_value;
        end
    end

    // window selection from the memory read words
    assign s1_c     = s1_sel_reg ? b_rd0_reg : a_rd0_reg;
    assign s1_right = s1_sel_reg ? b_rd1_reg : a_rd1_reg;
    assign s1_up    = s1_sel_reg ? a_rd0_reg : b_rd0_reg;

    // first stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= cells.valid;
    end

    // first stage payload; left is the previous cell's centre word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tag_reg  <= tag_next;
            s1_cell_reg <= cells.cell_value;
            s1_sel_reg  <= sel_reg;
            left_reg    <= s1_c;
        end
    end

    hds_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s1_valid_reg),
        .in_tag   (s1_tag_reg),
        .in_c     (s1_c),
        .in_cell  (s1_cell_reg),
        .in_up    (s1_up),
        .in_left  (left_reg),
        .in_right (s1_right),
        .coef     (coef_reg),
        .out_valid(ar_valid),
        .out_tag  (ar_tag),
        .out_c    (ar_c),
        .out_cell (ar_cell),
        .out_tx   (ar_tx),
        .out_ty   (ar_ty)
    );

    // saturating sum of the two weighted terms
    assign sum = SAT_W'(ar_tx) + SAT_W'(ar_ty);
    always_comb
    begin
        if (sum > SAT_W'(CELL_MAX))
            sat_val = CELL_MAX;
        else if (sum < SAT_W'(CELL_MIN))
            sat_val = CELL_MIN;
        else
            sat_val = CELL_W'(sum);
    end

    // result stage valid bits: load on advance, else drain one word at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_first_reg  <= 1'b0;
            out_second_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_first_reg  <= ar_valid && ar_tag.first_v;
            out_second_reg <= ar_valid && ar_tag.second_v;
        end
        else if (results.ready)
        begin
            out_first_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_val1_reg <= ar_tag.border ? ar_c : sat_val;
            out_val2_reg <= ar_cell;
            out_tag_reg  <= ar_tag;
        end
    end

    // result port: first word is the row above, second the cell itself
    assign results.valid      = out_first_reg || out_second_reg;
    assign results.new_value  = out_first_reg ? out_val1_reg : out_val2_reg;
    assign results.out_row    = out_first_reg ? (out_tag_reg.row - ROW_F_W'(1))
                                              : out_tag_reg.row;
    assign results.out_col    = out_tag_reg.col;
    assign results.frame_last = !out_first_reg && out_tag_reg.last;

    // checks
    `HDS_ASSERT_IMP(a_full_stall, (out_first_reg && out_second_reg), !cells.ready, "input taken while result stage full")
    `HDS_ASSERT_IMP(a_second_with_first, $rose(out_second_reg), out_first_reg, "second word loaded without first")
    `HDS_ASSERT_IMP(a_swap_on_row_end, !$stable(sel_reg), $past(accept && last_col), "row memories swapped inside a row")
    `HDS_ASSERT_NEXT(a_frame_wrap, (accept && last_col && last_row), (row_cnt_reg == '0 && col_cnt_reg == '0), "counters did not wrap at frame end")

endmodule

FILE: hw/rtl/hds_arith.sv
// pipelined five-point stencil arithmetic, four stages
module hds_arith import hds_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  hds_tag_t                 in_tag,
    input  logic signed [CELL_W-1:0] in_c,
    input  logic signed [CELL_W-1:0] in_cell,
    input  logic signed [CELL_W-1:0] in_up,
    input  logic signed [CELL_W-1:0] in_left,
    input  logic signed [CELL_W-1:0] in_right,
    input  hds_coef_t                coef,
    output logic                     out_valid,
    output hds_tag_t                 out_tag,
    output logic signed [CELL_W-1:0] out_c,
    output logic signed [CELL_W-1:0] out_cell,
    output logic signed [TERM_W-1:0] out_tx,
    output logic signed [TERM_W-1:0] out_ty
);

    logic                     s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    hds_tag_t                 s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    logic signed [CELL_W-1:0] s2_c_reg, s3_c_reg, s4_c_reg, s5_c_reg;
    logic signed [CELL_W-1:0] s2_cell_reg, s3_cell_reg, s4_cell_reg, s5_cell_reg;
    logic signed [CELL_W-1:0] s2_up_reg, s2_left_reg, s2_right_reg;
    logic signed [PROD_W-1:0] s2_px_reg, s2_py_reg, px_next, py_next;
    logic signed [SUM_W-1:0]  s3_vs_reg, s3_hs_reg, vs_next, hs_next;
    logic signed [PH_W-1:0]   s4_phx_reg, s4_phy_reg, phx_next, phy_next;
    logic signed [PL_W-1:0]   s4_plx_reg, s4_ply_reg, plx_next, ply_next;
    logic signed [TERM_W-1:0] s5_tx_reg, s5_ty_reg, tx_next, ty_next;

    // centre products
    assign px_next = in_c * coef.dx;
    assign py_next = in_c * coef.dy;

    // vertical and horizontal sums with floored centre term
    assign vs_next = SUM_W'(s2_up_reg) + SUM_W'(s2_cell_reg) + SUM_W'(s2_px_reg >>> FRAC_W);
    assign hs_next = SUM_W'(s2_left_reg) + SUM_W'(s2_right_reg)
                   + SUM_W'(s2_py_reg >>> FRAC_W);

    // weight products split into high part and unsigned low fraction
    assign phx_next = coef.wx * $signed(s3_vs_reg[SUM_W-1:FRAC_W]);
    assign phy_next = coef.wy * $signed(s3_hs_reg[SUM_W-1:FRAC_W]);
    assign plx_next = coef.wx * $signed({1'b0, s3_vs_reg[FRAC_W-1:0]});
    assign ply_next = coef.wy * $signed({1'b0, s3_hs_reg[FRAC_W-1:0]});

    // recombine into floor(w * v / 2^16)
    assign tx_next = TERM_W'(s4_phx_reg) + TERM_W'(s4_plx_reg >>> FRAC_W);
    assign ty_next = TERM_W'(s4_phy_reg) + TERM_W'(s4_ply_reg >>> FRAC_W);

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_tag_reg   <= in_tag;
            s2_c_reg     <= in_c;
            s2_cell_reg  <= in_cell;
            s2_up_reg    <= in_up;
            s2_left_reg  <= in_left;
            s2_right_reg <= in_right;
            s2_px_reg    <= px_next;
            s2_py_reg    <= py_next;

            s3_tag_reg   <= s2_tag_reg;
            s3_c_reg     <= s2_c_reg;
            s3_cell_reg  <= s2_cell_reg;
            s3_vs_reg    <= vs_next;
            s3_hs_reg    <= hs_next;

            s4_tag_reg   <= s3_tag_reg;
            s4_c_reg     <= s3_c_reg;
            s4_cell_reg  <= s3_cell_reg;
            s4_phx_reg   <= phx_next;
            s4_phy_reg   <= phy_next;
            s4_plx_reg   <= plx_next;
            s4_ply_reg   <= ply_next;

            s5_tag_reg   <= s4_tag_reg;
            s5_c_reg     <= s4_c_reg;
            s5_cell_reg  <= s4_cell_reg;
            s5_tx_reg    <= tx_next;
            s5_ty_reg    <= ty_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_tag   = s5_tag_reg;
    assign out_c     = s5_c_reg;
    assign out_cell  = s5_cell_reg;
    assign out_tx    = s5_tx_reg;
    assign out_ty    = s5_ty_reg;

endmodule

FILE: bench/testbench.sv
// testbench of the heat diffusion stencil step unit: predicted five-point updates checked word by word
module testbench;
    import hds_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_PAD    = 16;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_CELLS = 520;
    localparam int STORE_DEPTH  = 256;
    localparam int ROWS_CAP     = 1024;

    // Q16.16 constants of the usual explicit scheme
    localparam logic signed [CELL_W-1:0] Q_QUARTER   = 32'sh0000_4000;
    localparam logic signed [CELL_W-1:0] Q_ONE       = 32'sh0001_0000;
    localparam logic signed [CELL_W-1:0] Q_MINUS_TWO = 32'shfffe_0000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [CELL_W-1:0] value;
        logic [ROW_F_W-1:0]       row;
        logic [COL_F_W-1:0]       col;
        logic                     last;
    } cell_update_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hds_in_if  cell_ch ();
    hds_out_if result_ch ();

    heat_diffusion_stencil_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cell_ch),
        .results   (result_ch)
    );

    // predicted grid state: two previous rows, raster position, store roles
    logic signed [CELL_W-1:0] row_mem [2][STORE_DEPTH];
    int unsigned              cur_row;
    int unsigned              cur_col;
    logic                     mem_sel;

    // predicted register contents
    logic [GRID_ROWS_W-1:0]   grid_rows;
    logic [GRID_COLS_W-1:0]   grid_cols;
    logic signed [CELL_W-1:0] weight_x;
    logic signed [CELL_W-1:0] weight_y;
    logic signed [CELL_W-1:0] diag_x;
    logic signed [CELL_W-1:0] diag_y;

    cell_update_t pending_updates[$];
    int           error_count;
    int           cycle_count;
    int           burst_left;
    int           hold_request;
    int           cells_sent;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** heat_diffusion_stencil_step_unit: FAILED **");
        $finish;
    end

    function automatic int unsigned eff_rows();
        if (grid_rows < GRID_MIN)
            return GRID_MIN;
        if (grid_rows > ROWS_CAP)
            return ROWS_CAP;
        return grid_rows;
    endfunction

    function automatic int unsigned eff_cols();
        if (grid_cols < GRID_MIN)
            return GRID_MIN;
        if (grid_cols > STORE_DEPTH)
            return STORE_DEPTH;
        return grid_cols;
    endfunction

    // new value of the cell one row up, plus the last-row echo, for one accepted word
    function automatic void predict_cell_update(logic signed [CELL_W-1:0] cell_word);
        int unsigned              rows;
        int unsigned              cols;
        int unsigned              i;
        int unsigned              j;
        logic                     last_col;
        logic                     last_row;
        logic signed [CELL_W-1:0] centre;
        wide_t                    up, down, left, right, cw;
        wide_t                    wx_w, wy_w, dx_w, dy_w;
        wide_t                    vsum, hsum, total, sat_hi, sat_lo;
        cell_update_t             upd;
        rows = eff_rows();
        cols = eff_cols();
        i = cur_row;
        j = (cur_col < cols) ? cur_col : cols - 1;
        last_col = (cur_col >= cols - 1);
        last_row = (cur_row >= rows - 1);
        if (last_row)
            i = rows - 1;

        if (i >= 1)
        begin
            centre = row_mem[mem_sel][j];
            upd.value = centre;
            // interior: weighted vertical and horizontal sums, floor shifts, saturation
            if (i - 1 != 0 && j != 0 && j < cols - 1)
            begin
                up = row_mem[mem_sel ^ 1'b1][j];
                down = cell_word;
                left = row_mem[mem_sel][j - 1];
                right = row_mem[mem_sel][j + 1];
                cw = centre;
                wx_w = weight_x;
                wy_w = weight_y;
                dx_w = diag_x;
                dy_w = diag_y;
                sat_hi = CELL_MAX;
                sat_lo = CELL_MIN;
                vsum = up + down + ((cw * dx_w) >>> FRAC_W);
                hsum = left + right + ((cw * dy_w) >>> FRAC_W);
                total = ((wx_w * vsum) >>> FRAC_W) + ((wy_w * hsum) >>> FRAC_W);
                if (total > sat_hi)
                    upd.value = CELL_MAX;
                else if (total < sat_lo)
                    upd.value = CELL_MIN;
                else
                    upd.value = total[CELL_W-1:0];
            end
            upd.row = ROW_F_W'(i - 1);
            upd.col = COL_F_W'(j);
            upd.last = 1'b0;
            pending_updates.push_back(upd);
        end

        row_mem[mem_sel ^ 1'b1][j] = cell_word;

        // last row echoes each cell unchanged
        if (last_row)
        begin
            upd.value = cell_word;
            upd.row = ROW_F_W'(i);
            upd.col = COL_F_W'(j);
            upd.last = last_col;
            pending_updates.push_back(upd);
        end

        if (last_col)
        begin
            cur_col = 0;
            mem_sel = mem_sel ^ 1'b1;
            cur_row = last_row ? 0 : i + 1;
        end
        else
        begin
            cur_col = j + 1;
            cur_row = i;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        cell_update_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_updates.size() == 0)
            begin
                $error("unexpected word: row %0d col %0d new_value %0d",
                       result_ch.out_row, result_ch.out_col, result_ch.new_value);
                error_count++;
            end
            else
            begin
                want = pending_updates.pop_front();
                if (result_ch.new_value !== want.value)
                begin
                    $error("new_value: expected %0d, got %0d", want.value, result_ch.new_value);
                    error_count++;
                end
                if (result_ch.out_row !== want.row)
                begin
                    $error("out_row: expected %0d, got %0d", want.row, result_ch.out_row);
                    error_count++;
                end
                if (result_ch.out_col !== want.col)
                begin
                    $error("out_col: expected %0d, got %0d", want.col, result_ch.out_col);
                    error_count++;
                end
                if (result_ch.frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, got %0d", want.last, result_ch.frame_last);
                    error_count++;
                end
            end
        end
    end

    // result side: stall pattern in segments, long hold when asked
    initial
    begin
        int hold_left;
        int segment_left;
        int stall_mode;
        hold_left = 0;
        segment_left = 0;
        stall_mode = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (segment_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    segment_left = $urandom_range(10, 200);
                end
                segment_left--;
                case (stall_mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= $urandom_range(0, 1);
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ~result_ch.ready;
                endcase
            end
        end
    end

    // one cell word, sent in bursts with random gaps; entered and left at a falling edge
    task automatic send_cell(input logic signed [CELL_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                cell_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cell_ch.valid <= 1'b1;
        cell_ch.cell_value <= value;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        predict_cell_update(value);
        cells_sent++;
        @(negedge clk);
    endtask

    // wait until every update is out, then let the pipeline settle
    task automatic drain_results();
        cell_ch.valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic write_reg(input hds_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        case (idx)
            REG_GRID_ROWS: grid_rows = data[GRID_ROWS_W-1:0];
            REG_GRID_COLS: grid_cols = data[GRID_COLS_W-1:0];
            REG_WEIGHT_X:  weight_x = data;
            REG_WEIGHT_Y:  weight_y = data;
            REG_DIAG_X:    diag_x = data;
            REG_DIAG_Y:    diag_y = data;
            default: ;
        endcase
    endtask

    task automatic write_config(input int unsigned rows, input int unsigned cols,
                                input logic signed [CELL_W-1:0] wx,
                                input logic signed [CELL_W-1:0] wy,
                                input logic signed [CELL_W-1:0] dx,
                                input logic signed [CELL_W-1:0] dy);
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_GRID_COLS, cols);
        write_reg(REG_WEIGHT_X, wx);
        write_reg(REG_WEIGHT_Y, wy);
        write_reg(REG_DIAG_X, dx);
        write_reg(REG_DIAG_Y, dy);
        cfg_write <= 1'b0;
    endtask

    function automatic logic signed [CELL_W-1:0] random_cell();
        int v;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return CELL_MAX;
                    1: return CELL_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 2 ** 21);
                return v - 2 ** 20;
            end
        endcase
    endfunction

    // weight or centre factor, from typical scheme values to full range
    function automatic logic signed [CELL_W-1:0] random_coef(input logic centre);
        int v;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return centre ? Q_MINUS_TWO : Q_QUARTER;
            2: return centre ? Q_ONE : -Q_QUARTER;
            3:
            begin
                v = $urandom_range(0, 2 ** 18);
                return v - 2 ** 17;
            end
            4: return $urandom_range(0, 1) ? CELL_MAX : CELL_MIN;
            default: return centre ? 32'sd0 : -32'sd1;
        endcase
    endfunction

    function automatic int unsigned random_rows();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 2);
        return $urandom_range(3, 10);
    endfunction

    function automatic int unsigned random_cols();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2);
            1: return $urandom_range(17, 40);
            default: return $urandom_range(3, 16);
        endcase
    endfunction

    // random words until the raster position wraps to the frame start
    task automatic send_frame();
        do
            send_cell(random_cell());
        while (cur_row != 0 || cur_col != 0);
    endtask

    // one 8 x 8 frame on the register values left by reset
    task automatic test_reset_values();
        send_frame();
        drain_results();
    endtask

    // saturation both ways, with under-range grid sizes clamped up to three
    task automatic test_value_extremes();
        logic signed [CELL_W-1:0] mix [9];
        mix = '{CELL_MIN, CELL_MAX, 32'sd0, -32'sd1, CELL_MAX, 32'sd1, Q_ONE, CELL_MAX, CELL_MIN};
        write_config(0, 4, CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX);
        repeat (12) send_cell(CELL_MAX);
        drain_results();
        write_config(1, 0, CELL_MIN, CELL_MIN, CELL_MAX, CELL_MAX);
        foreach (mix[k])
            send_cell(mix[k]);
        drain_results();
    endtask

    // grid size rewritten partway through a frame
    task automatic test_resize_mid_frame();
        write_config(6, 7, Q_QUARTER, Q_QUARTER, Q_MINUS_TWO, Q_MINUS_TWO);
        repeat (2 * 7 + 4) send_cell(random_cell());
        drain_results();
        // row at the new last index and column past it: the next word closes the frame
        write_config(2, 3, Q_QUARTER, Q_QUARTER, Q_MINUS_TWO, Q_MINUS_TWO);
        send_frame();
        drain_results();
        // taller grid, narrower rows, partway through the second row
        write_config(5, 6, random_coef(0), random_coef(0), random_coef(1), random_coef(1));
        repeat (6 + 2) send_cell(random_cell());
        drain_results();
        write_config(9, 4, random_coef(0), random_coef(0), random_coef(1), random_coef(1));
        send_frame();
        drain_results();
    endtask

    // over-range sizes clamp to the largest grid; a small size then closes the frame early
    task automatic test_grid_extremes();
        write_config(2047, 511, Q_QUARTER, Q_QUARTER, Q_MINUS_TWO, Q_MINUS_TWO);
        repeat (2 * STORE_DEPTH + 3) send_cell(random_cell());
        drain_results();
        // row two is at the new last row and column three is past the new last column
        write_config(3, 3, random_coef(0), random_coef(0), random_coef(1), random_coef(1));
        send_frame();
        drain_results();
    endtask

    // result side held off long enough for the block to stall its input
    task automatic test_output_hold();
        write_config(6, 20, Q_QUARTER, Q_QUARTER, Q_MINUS_TWO, Q_MINUS_TWO);
        hold_request = 300;
        send_frame();
        drain_results();
    endtask

    // random sizes and coefficients, some frames resized partway
    task automatic test_random_frames();
        int          start;
        int unsigned split;
        start = cells_sent;
        while (cells_sent - start < RANDOM_CELLS)
        begin
            write_config(random_rows(), random_cols(), random_coef(0), random_coef(0),
                         random_coef(1), random_coef(1));
            if ($urandom_range(0, 3) == 0)
            begin
                split = $urandom_range(1, eff_rows() * eff_cols() - 1);
                repeat (split) send_cell(random_cell());
                drain_results();
                // columns may only shrink inside a frame
                write_config(random_rows(), $urandom_range(0, eff_cols()), random_coef(0),
                             random_coef(0), random_coef(1), random_coef(1));
            end
            repeat ($urandom_range(1, 2)) send_frame();
            drain_results();
        end
    endtask

    // stimulus and final verdict
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_GRID_ROWS;
        cfg_data = '0;
        cell_ch.valid = 1'b0;
        cell_ch.cell_value = '0;
        error_count = 0;
        burst_left = 0;
        hold_request = 0;
        cells_sent = 0;
        cur_row = 0;
        cur_col = 0;
        mem_sel = 1'b0;
        grid_rows = ROWS_RESET;
        grid_cols = COLS_RESET;
        weight_x = WEIGHT_RESET;
        weight_y = WEIGHT_RESET;
        diag_x = DIAG_RESET;
        diag_y = DIAG_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_value_extremes();
        test_resize_mid_frame();
        test_grid_extremes();
        test_output_hold();
        test_random_frames();

        repeat (DRAIN_PAD) @(posedge clk);
        if (error_count == 0 && pending_updates.size() == 0)
            $display("** heat_diffusion_stencil_step_unit: PASSED **");
        else
            $display("** heat_diffusion_stencil_step_unit: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hds_pkg.sv
hw/rtl/hds_in_if.sv
hw/rtl/hds_out_if.sv
hw/rtl/hds_arith.sv
hw/rtl/heat_diffusion_stencil_step_unit.sv
bench/testbench.sv
